### rtl/core/awtr_pkg.sv
// ----------------------------------------------------------------------------
// awtr_pkg
// Shared types, sizes and helpers of the area weighted thumbnail resampler.
// ----------------------------------------------------------------------------
package awtr_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = XW + YW;
    localparam int SZW        = 9;
    localparam int POSW       = 25;
    localparam int PORW       = 17;
    localparam int WGTW       = 33;
    localparam int PRODW      = WGTW + 8;
    localparam int SUMW       = 56;
    localparam int TOTW       = 49;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [1:0] CFG_SRC_W = 2'd0;
    localparam logic [1:0] CFG_SRC_H = 2'd1;
    localparam logic [1:0] CFG_DST_W = 2'd2;
    localparam logic [1:0] CFG_DST_H = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_RD,
        S_WGT,
        S_PROD,
        S_ACC,
        S_AVG,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_unit_ctl;

    // Zero counts as one, anything above the maximum as the maximum.
    function automatic logic [SZW-1:0] clamp_size(input logic [SZW-1:0] v,
                                                  input logic [SZW-1:0] maxv);
        logic [SZW-1:0] r;
        begin
            r = v;
            if (v == '0) begin
                r = SZW'(1);
            end else if (v > maxv) begin
                r = maxv;
            end
            return r;
        end
    endfunction

    // Overlap of pixel p with the span [s1, s2), Q0.16 with room for 1.0.
    function automatic logic [PORW-1:0] axis_portion(input logic [7:0]      p,
                                                     input logic [POSW-1:0] s1,
                                                     input logic [POSW-1:0] s2);
        logic [PORW-1:0] v;
        logic [POSW-1:0] span;
        begin
            span = s2 - s1;
            v    = PORW'(17'h10000);
            if ({1'b0, p} == s1[POSW-1:16]) begin
                v = PORW'(17'h10000) - {1'b0, s1[15:0]};
                if ({8'd0, v} > span) begin
                    v = span[PORW-1:0];
                end
            end else if ({1'b0, p} == s2[POSW-1:16]) begin
                v = {1'b0, s2[15:0]};
            end
            return v;
        end
    endfunction

endpackage

### rtl/core/awtr_frame_store.sv
// ----------------------------------------------------------------------------
// awtr_frame_store
// Source pixel memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module awtr_frame_store (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [awtr_pkg::AW-1:0] i_waddr,
    input  logic [23:0]          i_wdata,
    input  logic                 i_re,
    input  logic [awtr_pkg::AW-1:0] i_raddr,
    output logic [23:0]          o_rdata
);
    import awtr_pkg::*;

    logic [23:0] r_mem [0:(1<<AW)-1];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/awtr_pos_div.sv
// ----------------------------------------------------------------------------
// awtr_pos_div
// Restoring divider for footprint edges, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module awtr_pos_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [32:0]                i_dividend,
    input  logic [awtr_pkg::SZW-1:0]   i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [awtr_pkg::POSW-1:0]  o_quot
);
    import awtr_pkg::*;

    logic [32:0]    r_quot;
    logic [SZW:0]   r_rem;
    logic [SZW-1:0] r_dvs;
    logic [5:0]     r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [SZW:0]   rem_sh;
    logic           take;

    assign rem_sh = {r_rem[SZW-1:0], r_quot[32]};
    assign take   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient shifts in where the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= take ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quot <= {r_quot[31:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot[POSW-1:0];

endmodule

### rtl/core/awtr_avg_div.sv
// ----------------------------------------------------------------------------
// awtr_avg_div
// Divides the three channel sums by the total weight, nine quotient bits.
// ----------------------------------------------------------------------------
module awtr_avg_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [awtr_pkg::SUMW-1:0]  i_sum_r,
    input  logic [awtr_pkg::SUMW-1:0]  i_sum_g,
    input  logic [awtr_pkg::SUMW-1:0]  i_sum_b,
    input  logic [awtr_pkg::TOTW-1:0]  i_total,
    output awtr_pkg::t_unit_ctl        o_ctl,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue
);
    import awtr_pkg::*;

    logic [SUMW-1:0]   r_rem_r, r_rem_g, r_rem_b;
    logic [8:0]        r_q_r, r_q_g, r_q_b;
    logic [TOTW+7:0]   r_dv;
    logic              r_zero;
    logic [3:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              t_r, t_g, t_b;

    assign t_r = {1'b0, r_rem_r} >= r_dv;
    assign t_g = {1'b0, r_rem_g} >= r_dv;
    assign t_b = {1'b0, r_rem_b} >= r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd8;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem_r <= i_sum_r;
            r_rem_g <= i_sum_g;
            r_rem_b <= i_sum_b;
            r_dv    <= {i_total, 8'd0};
            r_zero  <= (i_total == '0);
            r_q_r   <= '0;
            r_q_g   <= '0;
            r_q_b   <= '0;
        end else if (r_busy) begin
            if (t_r) r_rem_r <= SUMW'({1'b0, r_rem_r} - r_dv);
            if (t_g) r_rem_g <= SUMW'({1'b0, r_rem_g} - r_dv);
            if (t_b) r_rem_b <= SUMW'({1'b0, r_rem_b} - r_dv);
            r_q_r <= {r_q_r[7:0], t_r};
            r_q_g <= {r_q_g[7:0], t_g};
            r_q_b <= {r_q_b[7:0], t_b};
            r_dv  <= r_dv >> 1;
        end
    end

    // Saturate at full scale; an empty footprint gives black.
    assign o_red   = r_zero ? 8'd0 : (r_q_r[8] ? 8'hFF : r_q_r[7:0]);
    assign o_green = r_zero ? 8'd0 : (r_q_g[8] ? 8'hFF : r_q_g[7:0]);
    assign o_blue  = r_zero ? 8'd0 : (r_q_b[8] ? 8'hFF : r_q_b[7:0]);

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;

endmodule

### rtl/core/area_weighted_thumbnail_resampler_core.sv
// ----------------------------------------------------------------------------
// area_weighted_thumbnail_resampler_core
// Stores RGB source pixels and produces area weighted thumbnail pixels.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    operation, col, row, in_red/green/blue
// result    out        o_valid / i_stall    out_col, out_row, out_red/green/blue
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A store request is written into the frame store when it is accepted. A
// compute request runs the four footprint edges through the shared serial
// divider (start, 33 quotient bits, done), walks each covered source pixel
// through memory read, weight, products and accumulate, and then runs the
// channel division; the next request is taken once the result is registered.
// Reset is synchronous; the frame store is not cleared.
// A finished result waits in the output register while new requests enter;
// a second finished result holds the input stalled until the first leaves.
// ----------------------------------------------------------------------------
module area_weighted_thumbnail_resampler_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [awtr_pkg::SZW-1:0]  i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_operation,
    input  logic [7:0]                i_col,
    input  logic [7:0]                i_row,
    input  logic [7:0]                i_in_red,
    input  logic [7:0]                i_in_green,
    input  logic [7:0]                i_in_blue,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_out_col,
    output logic [7:0]                o_out_row,
    output logic [7:0]                o_out_red,
    output logic [7:0]                o_out_green,
    output logic [7:0]                o_out_blue
);
    import awtr_pkg::*;

    t_state r_state, n_state;

    logic [SZW-1:0]  r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [SZW-1:0]  sw, sh, dw, dh;
    logic [7:0]      r_col, r_row;
    logic [1:0]      r_div_sel;
    logic [POSW-1:0] r_sx1, r_sx2, r_sy1, r_sy2;
    logic [7:0]      r_px, r_py;
    logic [PORW-1:0] r_xp, r_yp;
    logic [WGTW-1:0] r_w;
    logic [PRODW-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic [SUMW-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [TOTW-1:0] r_total;
    logic            r_out_valid;
    logic [7:0]      r_oc, r_or, r_ored, r_ogrn, r_oblu;

    logic            accept, take_out, out_free, in_range;
    logic            div_start, div_busy, div_done;
    logic [POSW-1:0] div_quot;
    logic [SZW-1:0]  fac, scale, dvs;
    logic [17:0]     num;
    logic            avg_start;
    t_unit_ctl       avg_ctl;
    logic [7:0]      avg_r, avg_g, avg_b;
    logic [23:0]     rdata;
    logic [SZW-1:0]  nx, ny;
    logic            x_more, y_more;
    logic            mem_we, mem_re;
    logic [PORW*2-1:0] wfull;

    assign sw = clamp_size(r_src_w, SZW'(MAX_WIDTH));
    assign sh = clamp_size(r_src_h, SZW'(MAX_HEIGHT));
    assign dw = clamp_size(r_dst_w, SZW'(MAX_WIDTH));
    assign dh = clamp_size(r_dst_h, SZW'(MAX_HEIGHT));

    assign accept   = i_valid && !o_stall;
    assign take_out = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign in_range = ({1'b0, i_col} < dw) && ({1'b0, i_row} < dh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SZW'(256);
            r_src_h <= SZW'(256);
            r_dst_w <= SZW'(64);
            r_dst_h <= SZW'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_W: r_src_w <= i_cfg_data;
                CFG_SRC_H: r_src_h <= i_cfg_data;
                CFG_DST_W: r_dst_w <= i_cfg_data;
                CFG_DST_H: r_dst_h <= i_cfg_data;
                default:   r_src_w <= r_src_w;
            endcase
        end
    end

    // Footprint edges: n * size << 16 / dst, for col, col+1, row, row+1.
    assign fac   = (r_div_sel[1] ? {1'b0, r_row} : {1'b0, r_col}) + SZW'(r_div_sel[0]);
    assign scale = r_div_sel[1] ? sh : sw;
    assign dvs   = r_div_sel[1] ? dh : dw;
    assign num   = {{SZW{1'b0}}, fac} * {{SZW{1'b0}}, scale};

    awtr_pos_div u_pos_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({num[16:0], 16'd0}),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign mem_we = accept && (i_operation == OP_STORE);

    awtr_frame_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({i_row[YW-1:0], i_col[XW-1:0]}),
        .i_wdata ({i_in_red, i_in_green, i_in_blue}),
        .i_re    (mem_re),
        .i_raddr ({r_py[YW-1:0], r_px[XW-1:0]}),
        .o_rdata (rdata)
    );

    awtr_avg_div u_avg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (avg_start),
        .i_sum_r (r_sum_r),
        .i_sum_g (r_sum_g),
        .i_sum_b (r_sum_b),
        .i_total (r_total),
        .o_ctl   (avg_ctl),
        .o_red   (avg_r),
        .o_green (avg_g),
        .o_blue  (avg_b)
    );

    assign nx     = {1'b0, r_px} + SZW'(1);
    assign ny     = {1'b0, r_py} + SZW'(1);
    assign x_more = {nx, 16'd0} < r_sx2;
    assign y_more = {ny, 16'd0} < r_sy2;
    assign wfull  = {{PORW{1'b0}}, r_xp} * {{PORW{1'b0}}, r_yp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_stall   = 1'b1;
        div_start = 1'b0;
        avg_start = 1'b0;
        mem_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (accept && i_operation == OP_COMPUTE && in_range) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                div_start = !div_busy && !div_done;
                if (div_done && r_div_sel == 2'd3) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_WGT;
            end
            S_WGT:  n_state = S_PROD;
            S_PROD: n_state = S_ACC;
            S_ACC: begin
                n_state = (x_more || y_more) ? S_RD : S_AVG;
            end
            S_AVG: begin
                avg_start = !avg_ctl.busy && !avg_ctl.done;
                if (avg_ctl.done) begin
                    n_state = out_free ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_sel <= '0;
        end else if (r_state == S_IDLE) begin
            r_div_sel <= '0;
        end else if (r_state == S_POS && div_done) begin
            r_div_sel <= r_div_sel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_operation == OP_COMPUTE) begin
            r_col   <= i_col;
            r_row   <= i_row;
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
            r_total <= '0;
        end
        if (r_state == S_POS && div_done) begin
            unique case (r_div_sel)
                2'd0: r_sx1 <= div_quot;
                2'd1: r_sx2 <= div_quot;
                2'd2: r_sy1 <= div_quot;
                2'd3: begin
                    r_sy2 <= div_quot;
                    r_px  <= r_sx1[23:16];
                    r_py  <= r_sy1[23:16];
                end
                default: r_sx1 <= r_sx1;
            endcase
        end
        if (r_state == S_RD) begin
            r_xp <= axis_portion(r_px, r_sx1, r_sx2);
            r_yp <= axis_portion(r_py, r_sy1, r_sy2);
        end
        if (r_state == S_WGT) begin
            r_w <= wfull[WGTW-1:0];
        end
        if (r_state == S_PROD) begin
            r_prod_r <= {{WGTW{1'b0}}, rdata[23:16]} * {8'd0, r_w};
            r_prod_g <= {{WGTW{1'b0}}, rdata[15:8]}  * {8'd0, r_w};
            r_prod_b <= {{WGTW{1'b0}}, rdata[7:0]}   * {8'd0, r_w};
        end
        if (r_state == S_ACC) begin
            r_sum_r <= r_sum_r + SUMW'(r_prod_r);
            r_sum_g <= r_sum_g + SUMW'(r_prod_g);
            r_sum_b <= r_sum_b + SUMW'(r_prod_b);
            r_total <= r_total + TOTW'(r_w);
            // Advance along the row, then wrap to the next source row.
            if (x_more) begin
                r_px <= nx[7:0];
            end else if (y_more) begin
                r_px <= r_sx1[23:16];
                r_py <= ny[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (((r_state == S_AVG && avg_ctl.done) || r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (take_out) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (((r_state == S_AVG && avg_ctl.done) || r_state == S_DONE) && out_free) begin
            r_oc   <= r_col;
            r_or   <= r_row;
            r_ored <= avg_r;
            r_ogrn <= avg_g;
            r_oblu <= avg_b;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_col   = r_oc;
    assign o_out_row   = r_or;
    assign o_out_red   = r_ored;
    assign o_out_green = r_ogrn;
    assign o_out_blue  = r_oblu;

    a_walk_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ({1'b0, r_px, 16'd0} < {1'b0, r_sx2}) &&
                              ({1'b0, r_py, 16'd0} < {1'b0, r_sy2}))
        else $error("source walk left the footprint");

    a_edges_then_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS && div_done && r_div_sel == 2'd3) |=> (r_state == S_RD))
        else $error("walk did not start after last footprint edge");

    a_weight_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AVG) |-> (r_total != '0))
        else $error("total weight is zero at division");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS || r_state == S_ACC || r_state == S_AVG) |-> o_stall)
        else $error("request taken during compute");

endmodule
